/* sv/tun_pkg.sv */
// Package for the triangle unit normal block: widths, types and constants.
// Depends on nothing; every other file imports it.
`default_nettype none
package tun_pkg;
   localparam int CoordBits = 24;
   localparam int EdgeBits = CoordBits + 1;
   localparam int CrossBits = 2 * EdgeBits + 1;
   localparam int MagBits = 31;
   localparam int SumBits = 2 * MagBits + 2;
   localparam int RootBits = SumBits / 2;
   localparam int FracBits = 15;
   localparam int NormBits = 16;
   localparam int QuoBits = MagBits + FracBits;
   localparam int ShiftBits = 6;
   localparam int CfgBits = 16;
   localparam logic [CfgBits-1:0] MinLengthReset = 16'd17;

   typedef struct packed {
      logic signed [CoordBits-1:0] v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, v3_x, v3_y, v3_z;
   } req_type;

   typedef struct packed {
      logic signed [NormBits-1:0] normal_x, normal_y, normal_z;
      logic degenerate;
   } rsp_type;

   // Work carried from cell to cell down the chain.
   typedef struct packed {
      logic                   valid;
      logic [2:0]             neg;
      logic [MagBits-1:0]     m0, m1, m2;
      logic [SumBits-1:0]     rem;
      logic [RootBits-1:0]    root;
      logic                   unscaled;
   } work_type;

   typedef struct packed {
      logic                   valid;
      logic [2:0]             neg;
      logic [MagBits-1:0]     m0, m1, m2;
      logic [RootBits-1:0]    len;
      logic                   degen;
      logic [QuoBits-1:0]     r0, r1, r2;
      logic [QuoBits-1:0]     q0, q1, q2;
   } div_type;
endpackage
`default_nettype wire

/* sv/tun_if.sv */
// Valid/ready channel interfaces for the request, response and configuration payloads.
// Depends on tun_pkg for payload types.
`default_nettype none
interface tun_req_if;
   import tun_pkg::*;
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tun_rsp_if;
   import tun_pkg::*;
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface tun_csr_if;
   import tun_pkg::*;
   logic valid;
   logic ready;
   logic [CfgBits-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/tun_sqrt_cell.sv */
// One cell of the square root chain: settles one root bit per cycle while advance is high.
// Depends on tun_pkg.
`default_nettype none
module tun_sqrt_cell
   import tun_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [ShiftBits-1:0] step,
   input  work_type                  up,
   output work_type                  down
);
   work_type down_ff, down_in;
   logic [ShiftBits-1:0] p;
   logic [SumBits+1:0] sub;
   logic [SumBits+1:0] trial;

   // The root bit settled here sits at position p; the trial subtracts
   // (2*root + 2^p) * 2^p from the remainder N - root^2.
   always_comb begin
      down_in = up;
      p = ShiftBits'(RootBits - 1) - step;
      sub = ((SumBits + 2)'({up.root, 1'b0}) | ((SumBits + 2)'(1) << p)) << p;
      trial = {2'b00, up.rem} - sub;
      if (!trial[SumBits+1]) begin
         down_in.rem = trial[SumBits-1:0];
         down_in.root = up.root | (RootBits'(1) << p);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff.valid <= 1'b0;
      end else if (advance) begin
         down_ff <= down_in;
      end
   end
   assign down = down_ff;
endmodule
`default_nettype wire

/* sv/tun_div_cell.sv */
// One cell of the divider chain: one quotient bit per component per cycle while advance is high.
// Depends on tun_pkg.
`default_nettype none
module tun_div_cell
   import tun_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 advance,
   input  wire logic [ShiftBits-1:0] step,
   input  div_type                   up,
   output div_type                   down
);
   div_type down_ff, down_in;

   function automatic logic [QuoBits:0] nxt(input logic [QuoBits-1:0] r,
                                            input logic b,
                                            input logic [RootBits-1:0] d);
      logic [QuoBits:0] t;
      logic [QuoBits:0] s;
      begin
         t = {r, b};
         s = t - (QuoBits + 1)'(d);
         if (!s[QuoBits])
            nxt = {1'b1, s[QuoBits-1:0]};
         else
            nxt = {1'b0, t[QuoBits-1:0]};
      end
   endfunction

   logic [ShiftBits-1:0] bit_pos;
   logic [QuoBits-1:0] n0, n1, n2;
   logic [QuoBits:0] a0, a1, a2;
   always_comb begin
      bit_pos = ShiftBits'(QuoBits - 1) - step;
      n0 = {up.m0, {FracBits{1'b0}}};
      n1 = {up.m1, {FracBits{1'b0}}};
      n2 = {up.m2, {FracBits{1'b0}}};
      a0 = nxt(up.r0, n0[bit_pos], up.len);
      a1 = nxt(up.r1, n1[bit_pos], up.len);
      a2 = nxt(up.r2, n2[bit_pos], up.len);
      down_in = up;
      down_in.r0 = a0[QuoBits-1:0];
      down_in.r1 = a1[QuoBits-1:0];
      down_in.r2 = a2[QuoBits-1:0];
      down_in.q0 = {up.q0[QuoBits-2:0], a0[QuoBits]};
      down_in.q1 = {up.q1[QuoBits-2:0], a1[QuoBits]};
      down_in.q2 = {up.q2[QuoBits-2:0], a2[QuoBits]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         down_ff.valid <= 1'b0;
      end else if (advance) begin
         down_ff <= down_in;
      end
   end
   assign down = down_ff;
endmodule
`default_nettype wire

/* sv/triangle_unit_normal.sv */
// Top level of the triangle unit normal block.
// Depends on tun_pkg, tun_if, tun_sqrt_cell and tun_div_cell.
`default_nettype none
// The block takes one triangle per cycle while the pipeline advances and
// returns its unit face normal in signed Q1.15. Requests flow through a
// fixed pipeline: edge products, cross product, block scaling, squaring, a
// chain of 32 square root cells (one root bit each), a chain of 46 divider
// cells (one quotient bit each, all three components in parallel) and a
// rounding and output stage. A new request is taken every cycle in which the
// whole pipeline advances, and it advances only when the output register is
// empty or taken, so a stalled consumer holds all work in place without loss.
// The divider yields a truncated quotient and its remainder; the output stage
// rounds to nearest, ties upward, by adding one when the remainder plus half
// the length reaches the length. min_length is read where the root leaves the
// square root chain and must only be written while the block is idle.
module triangle_unit_normal
   import tun_pkg::*;
(
   input wire logic clock,
   input wire logic reset,
   tun_req_if.sink   req,
   tun_rsp_if.source rsp,
   tun_csr_if.sink   csr
);
   logic advance;
   logic [CfgBits-1:0] min_len_ff;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         min_len_ff <= MinLengthReset;
      end else if (csr.valid) begin
         min_len_ff <= csr.data;
      end
   end

   logic rsp_valid_ff;
   rsp_type rsp_data_ff;
   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = advance;

   // Stage 1: edges and the six products.
   logic s1_valid_ff;
   logic signed [2*EdgeBits-1:0] p_ff [6];
   logic signed [EdgeBits-1:0] e1x, e1y, e1z, e2x, e2y, e2z;
   always_comb begin
      e1x = EdgeBits'(req.data.v2_x) - EdgeBits'(req.data.v1_x);
      e1y = EdgeBits'(req.data.v2_y) - EdgeBits'(req.data.v1_y);
      e1z = EdgeBits'(req.data.v2_z) - EdgeBits'(req.data.v1_z);
      e2x = EdgeBits'(req.data.v3_x) - EdgeBits'(req.data.v1_x);
      e2y = EdgeBits'(req.data.v3_y) - EdgeBits'(req.data.v1_y);
      e2z = EdgeBits'(req.data.v3_z) - EdgeBits'(req.data.v1_z);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= e1y * e2z;
         p_ff[1] <= e1z * e2y;
         p_ff[2] <= e1z * e2x;
         p_ff[3] <= e1x * e2z;
         p_ff[4] <= e1x * e2y;
         p_ff[5] <= e1y * e2x;
      end
   end

   // Stage 2: cross product magnitudes and signs.
   logic s2_valid_ff;
   logic [CrossBits-1:0] mag_ff [3];
   logic [2:0] neg_ff;
   logic signed [CrossBits-1:0] c [3];
   always_comb begin
      c[0] = CrossBits'(p_ff[0]) - CrossBits'(p_ff[1]);
      c[1] = CrossBits'(p_ff[2]) - CrossBits'(p_ff[3]);
      c[2] = CrossBits'(p_ff[4]) - CrossBits'(p_ff[5]);
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) begin
            neg_ff[i] <= c[i][CrossBits-1];
            mag_ff[i] <= c[i][CrossBits-1] ? -c[i] : c[i];
         end
      end
   end

   // Stage 3: block scaling to 31 bits; stage 4: the squares, summed at the chain input.
   logic [CrossBits-1:0] any_mag;
   logic [ShiftBits-1:0] shift;
   logic [MagBits-1:0] m [3];
   always_comb begin
      any_mag = mag_ff[0] | mag_ff[1] | mag_ff[2];
      shift = '0;
      for (int b = MagBits; b < CrossBits; b++) begin
         if (any_mag[b]) shift = ShiftBits'(b - MagBits + 1);
      end
      for (int i = 0; i < 3; i++) m[i] = MagBits'(mag_ff[i] >> shift);
   end
   logic s3_valid_ff;
   logic [MagBits-1:0] m_ff [3];
   logic [2:0] neg3_ff;
   logic small_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         m_ff <= m;
         neg3_ff <= neg_ff;
         small_ff <= (shift == '0);
      end
   end

   logic [2*MagBits-1:0] sq_ff [3];
   logic s4_valid_ff;
   logic [MagBits-1:0] m4_ff [3];
   logic [2:0] neg4_ff;
   logic small4_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (advance) begin
         s4_valid_ff <= s3_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < 3; i++) sq_ff[i] <= m_ff[i] * m_ff[i];
         m4_ff <= m_ff;
         neg4_ff <= neg3_ff;
         small4_ff <= small_ff;
      end
   end

   // Square root chain.
   work_type sq_chain [RootBits+1];
   always_comb begin
      sq_chain[0].valid = s4_valid_ff;
      sq_chain[0].neg = neg4_ff;
      sq_chain[0].m0 = m4_ff[0];
      sq_chain[0].m1 = m4_ff[1];
      sq_chain[0].m2 = m4_ff[2];
      sq_chain[0].rem = SumBits'(sq_ff[0]) + SumBits'(sq_ff[1]) + SumBits'(sq_ff[2]);
      sq_chain[0].root = '0;
      sq_chain[0].unscaled = small4_ff;
   end
   for (genvar k = 0; k < RootBits; k++) begin : g_sqrt
      tun_sqrt_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance), .step(ShiftBits'(k)),
         .up(sq_chain[k]), .down(sq_chain[k+1]));
   end

   // Threshold check and divider setup; the dividend is m*2^F.
   work_type sq_out;
   div_type dv_chain [QuoBits+1];
   assign sq_out = sq_chain[RootBits];
   always_comb begin
      dv_chain[0].valid = sq_out.valid;
      dv_chain[0].neg = sq_out.neg;
      dv_chain[0].len = sq_out.root;
      dv_chain[0].degen = (sq_out.root == '0) ||
         (sq_out.unscaled && (sq_out.root < RootBits'(min_len_ff)));
      dv_chain[0].m0 = sq_out.m0;
      dv_chain[0].m1 = sq_out.m1;
      dv_chain[0].m2 = sq_out.m2;
      dv_chain[0].r0 = '0;
      dv_chain[0].r1 = '0;
      dv_chain[0].r2 = '0;
      dv_chain[0].q0 = '0;
      dv_chain[0].q1 = '0;
      dv_chain[0].q2 = '0;
   end
   for (genvar k = 0; k < QuoBits; k++) begin : g_div
      tun_div_cell u_cell (
         .clock(clock), .reset(reset), .advance(advance), .step(ShiftBits'(k)),
         .up(dv_chain[k]), .down(dv_chain[k+1]));
   end

   // Rounding: compare remainder against length minus half length.
   div_type dv_out;
   logic [QuoBits-1:0] qr [3];
   logic [QuoBits-1:0] rr [3];
   logic [QuoBits-1:0] lim;
   logic signed [NormBits-1:0] comp [3];
   assign dv_out = dv_chain[QuoBits];
   always_comb begin
      lim = QuoBits'((1 << FracBits) - 1);
      rr[0] = dv_out.r0; rr[1] = dv_out.r1; rr[2] = dv_out.r2;
      qr[0] = dv_out.q0; qr[1] = dv_out.q1; qr[2] = dv_out.q2;
      for (int i = 0; i < 3; i++) begin
         if ((rr[i] + QuoBits'(dv_out.len >> 1)) >= QuoBits'(dv_out.len)) qr[i] = qr[i] + 1'b1;
         if (qr[i] > lim) qr[i] = lim;
         comp[i] = dv_out.neg[i] ? -NormBits'(qr[i]) : NormBits'(qr[i]);
      end
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= dv_out.valid;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff.degenerate <= dv_out.degen;
         rsp_data_ff.normal_x <= dv_out.degen ? '0 : comp[0];
         rsp_data_ff.normal_y <= dv_out.degen ? '0 : comp[1];
         rsp_data_ff.normal_z <= dv_out.degen ? '0 : comp[2];
      end
   end
   assign rsp.valid = rsp_valid_ff;
   assign rsp.data = rsp_data_ff;
endmodule
`default_nettype wire
